// File: src/rbc_pkg.sv
// rbc_pkg: constants shared by the rotated box corner datapath.
// Angle reduction limits, quadrant codes, CORDIC widths and arctangent table.
// No dependencies.
`default_nettype none

package rbc_pkg;

  localparam int ANGLE_BITS = 18;
  localparam int TURN_W     = 17;
  localparam int REST_W     = 15;

  localparam logic [TURN_W-1:0] FULL_TURN          = 17'd92160;
  localparam logic [TURN_W-1:0] QUARTER_TURN       = 17'd23040;
  localparam logic [TURN_W-1:0] HALF_TURN          = 17'd46080;
  localparam logic [TURN_W-1:0] THREE_QUARTER_TURN = 17'd69120;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam int CORDIC_STEPS = 17;
  localparam int CORDIC_XY_W  = 34;
  localparam int CORDIC_Z_W   = 26;

  localparam logic signed [CORDIC_XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // atan(2^-i) in 2^-16 degree
  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57
  };

endpackage

`default_nettype wire

// File: src/rotated_box_corners_core.sv
// rotated_box_corners_core: corners of a box rotated about its center.
// Angle reduction, a chain of rbc_cordic_cell stages, trig rounding and
// rbc_corner_calc. Uses rbc_pkg.
//
//   port group   dir  contents
//   s_axis_*     in   center_x, center_y, box_width, box_height, angle
//   m_axis_*     out  bl, br, tl, tr corners (x then y each)
//
// One request per cycle while no result is held; stages are angle reduce, quadrant split,
// 17 CORDIC cells, round/quadrant, multiply, combine, output register.
// The whole pipeline advances while the output register is empty or taken;
// a held result stalls every stage and drops s_axis_tready_o.
// Reset clears only the valid flags.
`default_nettype none

module rotated_box_corners_core #(
  parameter int TRIG_FRAC_BITS = 15,
  parameter int COORD_BITS     = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // center_x, center_y, box_width, box_height, angle from bit 0 up
  input  logic [((4*COORD_BITS+16+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // bl_x, bl_y, br_x, br_y, tl_x, tl_y, tr_x, tr_y from bit 0 up
  output logic [((8*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata_o
);
  import rbc_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int F      = TRIG_FRAC_BITS;
  localparam int HW     = CB - 2;
  localparam int TW     = F + 2;
  localparam int RW     = F + 4;
  localparam int SIDE_W = 2*CB + 2*HW + 3;
  localparam int OUT_W  = 8*(CB + 2);
  localparam int OUT_TDATA_W = ((OUT_W + 7)/8)*8;

  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // input unpack
  logic signed [CB-1:0]         in_cx, in_cy;
  logic        [CB-2:0]         in_w, in_h;
  logic signed [ANGLE_BITS-1:0] in_ang;
  assign in_cx  = s_axis_tdata_i[CB-1:0];
  assign in_cy  = s_axis_tdata_i[2*CB-1:CB];
  assign in_w   = s_axis_tdata_i[3*CB-2:2*CB];
  assign in_h   = s_axis_tdata_i[4*CB-3:3*CB-1];
  assign in_ang = s_axis_tdata_i[4*CB+ANGLE_BITS-3:4*CB-2];

  // stage 0: modulo 360 degrees
  logic signed [ANGLE_BITS:0] ang_s, ang_red, full_s;
  assign ang_s  = ANGLE_BITS'(in_ang) + (ANGLE_BITS+1)'(0);
  assign full_s = signed'({2'b00, FULL_TURN});

  always_comb begin
    if (ang_s < -full_s) begin
      ang_red = ang_s + (full_s <<< 1);
    end else if (ang_s < 0) begin
      ang_red = ang_s + full_s;
    end else if (ang_s >= full_s) begin
      ang_red = ang_s - full_s;
    end else begin
      ang_red = ang_s;
    end
  end

  logic                 v0_q;
  logic signed [CB-1:0] cx0_q, cy0_q;
  logic        [HW-1:0] hw0_q, hh0_q;
  logic    [TURN_W-1:0] a0_q;

  // stage 1: quadrant and rest
  logic    [1:0]        quad;
  logic    [TURN_W-1:0] base, rest_full;
  logic    [REST_W-1:0] rest;

  always_comb begin
    if (a0_q >= THREE_QUARTER_TURN) begin
      quad = QUAD_3;
      base = THREE_QUARTER_TURN;
    end else if (a0_q >= HALF_TURN) begin
      quad = QUAD_2;
      base = HALF_TURN;
    end else if (a0_q >= QUARTER_TURN) begin
      quad = QUAD_1;
      base = QUARTER_TURN;
    end else begin
      quad = QUAD_0;
      base = '0;
    end
  end

  assign rest_full = a0_q - base;
  assign rest      = rest_full[REST_W-1:0];

  logic                         v1_q;
  logic signed [CORDIC_Z_W-1:0] z1_q;
  logic        [SIDE_W-1:0]     side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx0_q   <= in_cx;
      cy0_q   <= in_cy;
      hw0_q   <= in_w[CB-2:1];
      hh0_q   <= in_h[CB-2:1];
      a0_q    <= ang_red[TURN_W-1:0];
      z1_q    <= signed'(CORDIC_Z_W'({rest, 8'h00}));
      side1_q <= {(rest == '0), quad, hh0_q, hw0_q, cy0_q, cx0_q};
    end
  end

  // CORDIC chain
  logic                          vc    [CORDIC_STEPS+1];
  logic signed [CORDIC_XY_W-1:0] xc    [CORDIC_STEPS+1];
  logic signed [CORDIC_XY_W-1:0] yc    [CORDIC_STEPS+1];
  logic signed [CORDIC_Z_W-1:0]  zc    [CORDIC_STEPS+1];
  logic        [SIDE_W-1:0]      sidec [CORDIC_STEPS+1];

  assign vc[0]    = v1_q;
  assign xc[0]    = CORDIC_GAIN_Q30;
  assign yc[0]    = '0;
  assign zc[0]    = z1_q;
  assign sidec[0] = side1_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    rbc_cordic_cell #(
      .STEP   (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vc[i]),
      .x_i     (xc[i]),
      .y_i     (yc[i]),
      .z_i     (zc[i]),
      .side_i  (sidec[i]),
      .valid_o (vc[i+1]),
      .x_o     (xc[i+1]),
      .y_o     (yc[i+1]),
      .z_o     (zc[i+1]),
      .side_o  (sidec[i+1])
    );
  end

  // round to F bits, clamp, special-case zero rest, apply quadrant
  logic [SIDE_W-1:0]   side_f;
  logic signed [CB-1:0] cx_f, cy_f;
  logic        [HW-1:0] hw_f, hh_f;
  logic        [1:0]    quad_f;
  logic                 rzero_f;
  assign side_f  = sidec[CORDIC_STEPS];
  assign cx_f    = side_f[CB-1:0];
  assign cy_f    = side_f[2*CB-1:CB];
  assign hw_f    = side_f[2*CB+HW-1:2*CB];
  assign hh_f    = side_f[2*CB+2*HW-1:2*CB+HW];
  assign quad_f  = side_f[2*CB+2*HW+1:2*CB+2*HW];
  assign rzero_f = side_f[SIDE_W-1];

  localparam logic signed [CORDIC_XY_W-1:0] Half = CORDIC_XY_W'(64'd1 << (29 - F));
  localparam logic signed [RW-1:0]          One  = RW'(64'd1 << F);

  logic signed [CORDIC_XY_W-1:0] xr, yr, xsh, ysh;
  logic signed [RW-1:0]          xt, yt, xcl, ycl;
  logic signed [TW-1:0]          bs, bc, s_d, c_d;

  assign xr  = xc[CORDIC_STEPS] + Half;
  assign yr  = yc[CORDIC_STEPS] + Half;
  assign xsh = xr >>> (30 - F);
  assign ysh = yr >>> (30 - F);
  assign xt  = xsh[RW-1:0];
  assign yt  = ysh[RW-1:0];

  always_comb begin
    if (xt > One) begin
      xcl = One;
    end else if (xt < -One) begin
      xcl = -One;
    end else begin
      xcl = xt;
    end
    if (yt > One) begin
      ycl = One;
    end else if (yt < -One) begin
      ycl = -One;
    end else begin
      ycl = yt;
    end
    if (rzero_f) begin
      bs = '0;
      bc = One[TW-1:0];
    end else begin
      bs = ycl[TW-1:0];
      bc = xcl[TW-1:0];
    end
    case (quad_f)
      QUAD_0: begin
        s_d = bs;
        c_d = bc;
      end
      QUAD_1: begin
        s_d = bc;
        c_d = -bs;
      end
      QUAD_2: begin
        s_d = -bs;
        c_d = -bc;
      end
      QUAD_3: begin
        s_d = -bc;
        c_d = bs;
      end
      default: begin
        s_d = bs;
        c_d = bc;
      end
    endcase
  end

  logic                 v2_q;
  logic signed [TW-1:0] s2_q, c2_q;
  logic signed [CB-1:0] cx2_q, cy2_q;
  logic        [HW-1:0] hw2_q, hh2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= vc[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q  <= s_d;
      c2_q  <= c_d;
      cx2_q <= cx_f;
      cy2_q <= cy_f;
      hw2_q <= hw_f;
      hh2_q <= hh_f;
    end
  end

  logic [OUT_W-1:0] corner;

  rbc_corner_calc #(
    .COORD_BITS     (CB),
    .TRIG_FRAC_BITS (F)
  ) u_corner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v2_q),
    .cx_i     (cx2_q),
    .cy_i     (cy2_q),
    .hw_i     (hw2_q),
    .hh_i     (hh2_q),
    .sin_i    (s2_q),
    .cos_i    (c2_q),
    .valid_o  (m_axis_tvalid_o),
    .corner_o (corner)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(corner);

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while result held");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  a_angle_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> (a0_q < FULL_TURN))
    else $error("reduced angle out of range");

  a_rest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> (rest_full < QUARTER_TURN))
    else $error("quadrant rest out of range");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ((RW'(s2_q) <= One) && (RW'(s2_q) >= -One) &&
              (RW'(c2_q) <= One) && (RW'(c2_q) >= -One)))
    else $error("sin/cos outside unit range");

endmodule

`default_nettype wire

// File: src/rbc_cordic_cell.sv
// rbc_cordic_cell: one rotation-mode CORDIC micro-rotation, registered.
// Carries opaque side data alongside x, y, z. Depends on rbc_pkg.
`default_nettype none

module rbc_cordic_cell #(
  parameter int unsigned STEP   = 0,
  parameter int          SIDE_W = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic signed [rbc_pkg::CORDIC_XY_W-1:0]   x_i,
  input  logic signed [rbc_pkg::CORDIC_XY_W-1:0]   y_i,
  input  logic signed [rbc_pkg::CORDIC_Z_W-1:0]    z_i,
  input  logic        [SIDE_W-1:0]                 side_i,
  output logic                                     valid_o,
  output logic signed [rbc_pkg::CORDIC_XY_W-1:0]   x_o,
  output logic signed [rbc_pkg::CORDIC_XY_W-1:0]   y_o,
  output logic signed [rbc_pkg::CORDIC_Z_W-1:0]    z_o,
  output logic        [SIDE_W-1:0]                 side_o
);
  import rbc_pkg::*;

  localparam logic signed [CORDIC_Z_W-1:0] Atan = CORDIC_Z_W'(ATAN_TAB[STEP]);

  logic                          valid_q;
  logic signed [CORDIC_XY_W-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [CORDIC_Z_W-1:0]  z_q, z_d;
  logic        [SIDE_W-1:0]      side_q;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_comb begin
    if (!z_i[CORDIC_Z_W-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// File: src/rbc_corner_calc.sv
// rbc_corner_calc: multiply half sizes by sin/cos, combine per corner,
// truncate toward zero and add the center; three register stages. Uses rbc_pkg.
`default_nettype none

module rbc_corner_calc #(
  parameter int COORD_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [COORD_BITS-1:0]      cx_i,
  input  logic signed [COORD_BITS-1:0]      cy_i,
  input  logic        [COORD_BITS-3:0]      hw_i,
  input  logic        [COORD_BITS-3:0]      hh_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sin_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cos_i,
  output logic                              valid_o,
  // bl_x, bl_y, br_x, br_y, tl_x, tl_y, tr_x, tr_y from bit 0 up
  output logic [8*(COORD_BITS+2)-1:0]       corner_o
);
  import rbc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int F  = TRIG_FRAC_BITS;
  localparam int PW = CB + F + 1;
  localparam int SW = PW + 1;
  localparam int OW = CB + 2;
  localparam logic signed [SW-1:0] Bias = SW'((64'd1 << F) - 64'd1);

  logic signed [CB-2:0] hw_s, hh_s;
  assign hw_s = signed'({1'b0, hw_i});
  assign hh_s = signed'({1'b0, hh_i});

  // multiply stage
  logic                 vm_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p1_d, p2_d, p3_d, p4_d;
  logic signed [CB-1:0] cxm_q, cym_q;

  assign p1_d = PW'(hw_s) * PW'(cos_i);
  assign p2_d = PW'(hh_s) * PW'(sin_i);
  assign p3_d = PW'(hw_s) * PW'(sin_i);
  assign p4_d = PW'(hh_s) * PW'(cos_i);

  // combine stage
  logic                 vs_q;
  logic signed [SW-1:0] sum_q [8];
  logic signed [SW-1:0] sum_d [8];
  logic signed [SW-1:0] e1, e2, e3, e4;
  logic signed [CB-1:0] cxs_q, cys_q;

  assign e1 = SW'(p1_q);
  assign e2 = SW'(p2_q);
  assign e3 = SW'(p3_q);
  assign e4 = SW'(p4_q);

  always_comb begin
    sum_d[0] = e2 - e1;
    sum_d[1] = -e3 - e4;
    sum_d[2] = e1 + e2;
    sum_d[3] = e3 - e4;
    sum_d[4] = -e1 - e2;
    sum_d[5] = e4 - e3;
    sum_d[6] = e1 - e2;
    sum_d[7] = e3 + e4;
  end

  // truncate and offset stage
  logic                  vo_q;
  logic [8*OW-1:0]       corner_q, corner_d;

  always_comb begin
    logic signed [SW-1:0] rnd;
    logic signed [SW-1:0] sh;
    logic signed [OW-1:0] cen;
    corner_d = '0;
    for (int k = 0; k < 8; k++) begin
      rnd = sum_q[k] + (sum_q[k][SW-1] ? Bias : '0);
      sh  = rnd >>> F;
      cen = (k % 2 == 0) ? OW'(cxs_q) : OW'(cys_q);
      corner_d[k*OW +: OW] = sh[OW-1:0] + cen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vs_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
      vs_q <= vm_q;
      vo_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q     <= p1_d;
      p2_q     <= p2_d;
      p3_q     <= p3_d;
      p4_q     <= p4_d;
      cxm_q    <= cx_i;
      cym_q    <= cy_i;
      sum_q    <= sum_d;
      cxs_q    <= cxm_q;
      cys_q    <= cym_q;
      corner_q <= corner_d;
    end
  end

  assign valid_o  = vo_q;
  assign corner_o = corner_q;

endmodule

`default_nettype wire
